/* hw/rtl/baro_sensor_compensation_assert.svh */
// ============================================================================
// Assertion macros for the barometric compensation block
// Shared property forms used by the port checker.
// ============================================================================
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define BSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// Condition in one cycle implies consequence in the next cycle.
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

/* hw/rtl/bsc_pkg.sv */
// ============================================================================
// Barometric compensation package
// Widths, register indexes and sign-extension helpers.
// ============================================================================
package bsc_pkg;

    localparam int RAW_W        = 20;
    localparam int ADC_BITS_DEF = 20;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 64;

    typedef enum logic [1:0] {
        REG_CAL_TEMP    = 2'd0,
        REG_CAL_PRESS_A = 2'd1,
        REG_CAL_PRESS_B = 2'd2,
        REG_CAL_P9      = 2'd3
    } reg_idx_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx48(input logic [47:0] v);
        sx48 = {{16{v[47]}}, v};
    endfunction

    function automatic logic [63:0] sx49(input logic [48:0] v);
        sx49 = {{15{v[48]}}, v};
    endfunction

endpackage

/* hw/rtl/baro_sensor_compensation.sv */
// ============================================================================
// Barometric sensor compensation
// Integer temperature and 64-bit pressure compensation, fully pipelined.
// ============================================================================
// Usage: a request carries one raw temperature and one raw pressure reading
// on the req channel (req_valid / req_stall). Each request yields exactly one
// result on the rsp channel (rsp_valid / rsp_stall): temperature in 0.01 degC,
// pressure in Q24.8 pascals and a flag for a zero pressure divisor.
// The pipeline has 81 register stages: 11 for the calibration arithmetic, one
// to take magnitudes, 64 radix-2 stages of the signed divider, and 5 for the
// final pressure correction ending in the output register. One request is
// taken in every cycle while the pipeline advances. All stages advance
// together. When the output register holds a result and rsp_stall is high,
// the whole pipeline freezes and req_stall goes high, so nothing is lost or
// repeated. Reset clears every valid bit and the four calibration registers.
// Register i sits at byte address 8*i. The user must write calibration
// through the APB port only while the pipeline is empty; the block itself
// does not enforce this.
// ============================================================================
module baro_sensor_compensation
    import bsc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [RAW_W-1:0]         raw_temperature,
    input  logic [RAW_W-1:0]         raw_pressure,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic signed [15:0]       temperature_centi,
    output logic [31:0]              pressure_q24_8,
    output logic                     divisor_zero,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int NDIV  = 64;
    localparam int DEPTH = 12 + NDIV + 5;
    localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);

    // Calibration registers.
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg;
    logic [63:0] cal_press_b_reg;
    logic [15:0] cal_p9_reg;
    reg_idx_t    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_p9_reg      <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_CAL_TEMP:    cal_temp_reg    <= pwdata[47:0];
                REG_CAL_PRESS_A: cal_press_a_reg <= pwdata;
                REG_CAL_PRESS_B: cal_press_b_reg <= pwdata;
                REG_CAL_P9:      cal_p9_reg      <= pwdata[15:0];
                default:         cal_p9_reg      <= cal_p9_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CAL_TEMP:    prdata = {16'b0, cal_temp_reg};
            REG_CAL_PRESS_A: prdata = cal_press_a_reg;
            REG_CAL_PRESS_B: prdata = cal_press_b_reg;
            REG_CAL_P9:      prdata = {48'b0, cal_p9_reg};
            default:         prdata = '0;
        endcase
    end

    // Calibration words.
    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_temp_reg[15:0];
    assign t2 = $signed(cal_temp_reg[31:16]);
    assign t3 = $signed(cal_temp_reg[47:32]);
    assign p1 = cal_press_a_reg[15:0];
    assign p2 = $signed(cal_press_a_reg[31:16]);
    assign p3 = $signed(cal_press_a_reg[47:32]);
    assign p4 = $signed(cal_press_a_reg[63:48]);
    assign p5 = $signed(cal_press_b_reg[15:0]);
    assign p6 = $signed(cal_press_b_reg[31:16]);
    assign p7 = $signed(cal_press_b_reg[47:32]);
    assign p8 = $signed(cal_press_b_reg[63:48]);
    assign p9 = $signed(cal_p9_reg);

    // Pipeline control: one shared advance for every stage.
    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    assign adv       = !(vld_reg[DEPTH-1] && rsp_stall);
    assign req_stall = !adv;
    assign rsp_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], req_valid};
        end
    end

    // ---------------------------------------------------------------- S1..S5
    // Temperature path; the result saturates to the signed 16-bit range.
    logic        [RAW_W-1:0] at1_reg, ap1_reg, ap2_reg, ap3_reg, ap4_reg;
    logic        [RAW_W-1:0] ap5_reg, ap6_reg, ap7_reg, ap8_reg;
    logic signed [18:0]      d1;
    logic signed [17:0]      d2;
    logic signed [34:0]      m1_next, m1_reg;
    logic signed [35:0]      sq_next, sq_reg;
    logic signed [23:0]      v1t_reg, sqs;
    logic signed [39:0]      q_next, q_reg;
    logic signed [31:0]      fine_reg, a5_reg;
    logic signed [35:0]      t5;
    logic signed [35:0]      tcw;
    logic signed [15:0]      tc_next;
    logic signed [15:0]      tc5_reg, tc6_reg, tc7_reg, tc8_reg, tc9_reg, tc10_reg, tc11_reg;

    assign d1      = $signed({2'b0, at1_reg[RAW_W-1:3]}) - $signed({2'b0, t1, 1'b0});
    assign d2      = $signed({2'b0, at1_reg[RAW_W-1:4]}) - $signed({2'b0, t1});
    assign m1_next = d1 * t2;
    assign sq_next = d2 * d2;
    assign sqs     = $signed(sq_reg[35:12]);
    assign q_next  = sqs * t3;
    assign t5      = $signed({{4{fine_reg[31]}}, fine_reg}) * 36'sd5 + 36'sd128;
    assign tcw     = t5 >>> 8;

    always_comb
    begin
        if (tcw > 36'sd32767)
        begin
            tc_next = 16'sh7fff;
        end
        else if (tcw < -36'sd32768)
        begin
            tc_next = 16'sh8000;
        end
        else
        begin
            tc_next = tcw[15:0];
        end
    end

    // ---------------------------------------------------------------- S6..S11
    // Pressure calibration terms, modulo 2^64.
    logic signed [63:0] aa_next;
    logic        [63:0] aa_reg;
    logic signed [47:0] ap5m_next, ap2m_next, ap5m_reg, ap2m_reg;
    logic signed [67:0] b1_prod, c1_prod;
    logic        [63:0] b1_reg, c1_reg, bt_reg, ct_reg;
    logic        [63:0] b8_reg, a28_reg;
    logic        [63:0] x9_reg, n09_reg;
    logic        [20:0] pp21;
    logic        [47:0] xl_next, xl_reg;
    logic        [31:0] xh_next, xh_reg;
    logic        [43:0] nl_next, nl_reg;
    logic        [31:0] nh_next, nh_reg;
    logic        [63:0] dsum;
    logic        [63:0] den11_reg, num11_reg;

    assign aa_next   = a5_reg * a5_reg;
    assign ap5m_next = a5_reg * p5;
    assign ap2m_next = a5_reg * p2;
    assign b1_prod   = $signed({1'b0, aa_reg[50:0]}) * p6;
    assign c1_prod   = $signed({1'b0, aa_reg[50:0]}) * p3;
    assign pp21      = 21'd1048576 - {1'b0, ap8_reg};
    assign xl_next   = x9_reg[31:0] * p1;
    assign xh_next   = x9_reg[63:32] * {16'b0, p1};
    assign nl_next   = n09_reg[31:0] * 12'd3125;
    assign nh_next   = n09_reg[63:32] * 32'd3125;
    assign dsum      = {16'b0, xl_reg} + {xh_reg, 32'b0};

    // ---------------------------------------------------------------- divider
    // Index 0 holds the magnitudes; stage k produces quotient bit 64-k.
    logic        [63:0] dr_reg   [0:NDIV];
    logic        [63:0] dn_reg   [0:NDIV];
    logic        [63:0] dmd_reg  [0:NDIV];
    logic               dneg_reg [0:NDIV];
    logic               dzro_reg [0:NDIV];
    logic signed [15:0] dtc_reg  [0:NDIV];

    genvar k;
    generate
        for (k = 1; k <= NDIV; k++)
        begin : g_div
            logic [64:0] trial;
            logic [64:0] diff;
            logic        ge;

            assign trial = {dr_reg[k-1], dn_reg[k-1][63]};
            assign diff  = trial - {1'b0, dmd_reg[k-1]};
            assign ge    = (trial >= {1'b0, dmd_reg[k-1]});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dr_reg[k]   <= ge ? diff[63:0] : trial[63:0];
                    dn_reg[k]   <= {dn_reg[k-1][62:0], ge};
                    dmd_reg[k]  <= dmd_reg[k-1];
                    dneg_reg[k] <= dneg_reg[k-1];
                    dzro_reg[k] <= dzro_reg[k-1];
                    dtc_reg[k]  <= dtc_reg[k-1];
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------- P1..P5
    // Final correction: quadratic P9 term, linear P8 term, P7 offset.
    logic        [63:0] pq1_reg, pq2_reg, pq3_reg, pq4_reg;
    logic        [63:0] s_next, s2_reg;
    logic signed [66:0] ps9_prod;
    logic        [63:0] ps9_reg;
    logic signed [48:0] pl8_next, pl8_reg;
    logic        [31:0] ph8_next, ph8_reg;
    logic        [63:0] pp0_next, pp0_reg;
    logic        [31:0] pp1_next, pp2_next, pp1_reg, pp2_reg;
    logic        [63:0] v2_next, v23_reg, v24_reg, v14_reg;
    logic        [63:0] v1_next;
    logic        [63:0] fsum;
    logic        [63:0] fres;
    logic               z1_reg, z2_reg, z3_reg, z4_reg;
    logic signed [15:0] tp1_reg, tp2_reg, tp3_reg, tp4_reg;

    assign s_next   = $signed(pq1_reg) >>> 13;
    assign ps9_prod = $signed(s_next[50:0]) * p9;
    assign pl8_next = $signed({1'b0, pq1_reg[31:0]}) * p8;
    assign ph8_next = pq1_reg[63:32] * {{16{p8[15]}}, p8};
    assign pp0_next = {32'b0, ps9_reg[31:0]} * {32'b0, s2_reg[31:0]};
    assign pp1_next = ps9_reg[31:0] * s2_reg[63:32];
    assign pp2_next = ps9_reg[63:32] * s2_reg[31:0];
    assign v2_next  = $signed(sx49(pl8_reg) + {ph8_reg, 32'b0}) >>> 19;
    assign v1_next  = $signed(pp0_reg + {pp1_reg + pp2_reg, 32'b0}) >>> 25;
    assign fsum     = pq4_reg + v14_reg + v24_reg;
    assign fres     = $unsigned($signed(fsum) >>> 8) + (sx16(p7) << 4);

    // Payload registers: no reset, all frozen while the output is stalled.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // S1
            at1_reg   <= raw_temperature & ADC_MASK;
            ap1_reg   <= raw_pressure & ADC_MASK;
            // S2
            m1_reg    <= m1_next;
            sq_reg    <= sq_next;
            ap2_reg   <= ap1_reg;
            // S3
            v1t_reg   <= m1_reg[34:11];
            q_reg     <= q_next;
            ap3_reg   <= ap2_reg;
            // S4
            fine_reg  <= {{8{v1t_reg[23]}}, v1t_reg} + {{6{q_reg[39]}}, q_reg[39:14]};
            ap4_reg   <= ap3_reg;
            // S5
            a5_reg    <= fine_reg - 32'sd128000;
            tc5_reg   <= tc_next;
            ap5_reg   <= ap4_reg;
            // S6
            aa_reg    <= aa_next;
            ap5m_reg  <= ap5m_next;
            ap2m_reg  <= ap2m_next;
            tc6_reg   <= tc5_reg;
            ap6_reg   <= ap5_reg;
            // S7
            b1_reg    <= b1_prod[63:0];
            c1_reg    <= c1_prod[63:0];
            bt_reg    <= sx48(ap5m_reg) << 17;
            ct_reg    <= sx48(ap2m_reg) << 12;
            tc7_reg   <= tc6_reg;
            ap7_reg   <= ap6_reg;
            // S8
            b8_reg    <= b1_reg + bt_reg + (sx16(p4) << 35);
            a28_reg   <= $unsigned($signed(c1_reg) >>> 8) + ct_reg;
            tc8_reg   <= tc7_reg;
            ap8_reg   <= ap7_reg;
            // S9
            x9_reg    <= 64'h0000_8000_0000_0000 + a28_reg;
            n09_reg   <= ({43'b0, pp21} << 31) - b8_reg;
            tc9_reg   <= tc8_reg;
            // S10
            xl_reg    <= xl_next;
            xh_reg    <= xh_next;
            nl_reg    <= nl_next;
            nh_reg    <= nh_next;
            tc10_reg  <= tc9_reg;
            // S11
            den11_reg <= $signed(dsum) >>> 33;
            num11_reg <= {20'b0, nl_reg} + {nh_reg, 32'b0};
            tc11_reg  <= tc10_reg;
            // S12: magnitudes and sign of the quotient
            dr_reg[0]   <= '0;
            dn_reg[0]   <= num11_reg[63] ? (64'd0 - num11_reg) : num11_reg;
            dmd_reg[0]  <= den11_reg[63] ? (64'd0 - den11_reg) : den11_reg;
            dneg_reg[0] <= num11_reg[63] ^ den11_reg[63];
            dzro_reg[0] <= (den11_reg == 64'd0);
            dtc_reg[0]  <= tc11_reg;
            // P1
            pq1_reg   <= dneg_reg[NDIV] ? (64'd0 - dn_reg[NDIV]) : dn_reg[NDIV];
            z1_reg    <= dzro_reg[NDIV];
            tp1_reg   <= dtc_reg[NDIV];
            // P2
            s2_reg    <= s_next;
            ps9_reg   <= ps9_prod[63:0];
            pl8_reg   <= pl8_next;
            ph8_reg   <= ph8_next;
            pq2_reg   <= pq1_reg;
            z2_reg    <= z1_reg;
            tp2_reg   <= tp1_reg;
            // P3
            pp0_reg   <= pp0_next;
            pp1_reg   <= pp1_next;
            pp2_reg   <= pp2_next;
            v23_reg   <= v2_next;
            pq3_reg   <= pq2_reg;
            z3_reg    <= z2_reg;
            tp3_reg   <= tp2_reg;
            // P4
            v14_reg   <= v1_next;
            v24_reg   <= v23_reg;
            pq4_reg   <= pq3_reg;
            z4_reg    <= z3_reg;
            tp4_reg   <= tp3_reg;
            // P5: output register
            temperature_centi <= tp4_reg;
            pressure_q24_8    <= z4_reg ? 32'd0 : fres[31:0];
            divisor_zero      <= z4_reg;
        end
    end

endmodule

/* hw/rtl/bsc_checker.sv */
// ============================================================================
// Barometric compensation port checker
// Watches the top-level ports and checks flow control and result rules.
// ============================================================================
`include "baro_sensor_compensation_assert.svh"

module bsc_checker
    import bsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] pressure_q24_8,
    input logic        divisor_zero,
    input logic        pready
);

    // A held result stays offered until it is taken.
    `BSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

    // Requests are refused only while a finished result waits.
    `BSC_ASSERT_NOW(a_req_stall_cause, req_stall, rsp_valid && rsp_stall)

    // A zero divisor forces the pressure to zero.
    `BSC_ASSERT_NOW(a_zero_div, rsp_valid && divisor_zero, pressure_q24_8 == 32'd0)

    // The register port never inserts wait states.
    `BSC_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .pressure_q24_8 (pressure_q24_8),
    .divisor_zero   (divisor_zero),
    .pready         (pready)
);
